>>> rtl/tsr_pkg.sv
// Shared constants, register indexes and types of the two-axis servo slew ramp.
package tsr_pkg;

    localparam int PULSE_W   = 16;
    localparam int SPEED_W   = 8;
    localparam int CNT_W     = 24;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILT_UPPER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LOWER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_UPPER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_HOME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_HOME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd7;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MOVE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;

    // op codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam logic [PULSE_W-1:0] UPPER_DEFAULT = 16'hFFFF;
    localparam logic [PULSE_W-1:0] LOWER_DEFAULT = 16'd0;
    localparam logic [PULSE_W-1:0] HOME_DEFAULT  = 16'd1500;
    localparam logic [PULSE_W-1:0] SCALE_DEFAULT = 16'd10000;
    localparam logic [PULSE_W-1:0] HOLD_DEFAULT  = 16'd350;
    localparam logic [PULSE_W-1:0] HOLD_SAT      = 16'hFFFF;

    typedef struct packed {
        logic [PULSE_W-1:0] tilt_upper;
        logic [PULSE_W-1:0] tilt_lower;
        logic [PULSE_W-1:0] pan_upper;
        logic [PULSE_W-1:0] pan_lower;
        logic [PULSE_W-1:0] step_scale;
        logic [PULSE_W-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic [PULSE_W-1:0] target_tilt;
        logic [PULSE_W-1:0] target_pan;
        logic [SPEED_W-1:0] speed;
    } t_cmd;

    typedef struct packed {
        logic [PULSE_W-1:0] tilt_pulse;
        logic [PULSE_W-1:0] pan_pulse;
        logic               power_on;
        logic               busy_res;
    } t_res;

endpackage

>>> rtl/tsr_if.sv
// Channel interfaces: command input, result output and register write port.
interface tsr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [tsr_pkg::PULSE_W-1:0]   target_tilt;
    logic [tsr_pkg::PULSE_W-1:0]   target_pan;
    logic [tsr_pkg::SPEED_W-1:0]   speed;

    modport source (output valid, op, target_tilt, target_pan, speed, input ready);
    modport sink   (input valid, op, target_tilt, target_pan, speed, output ready);
endinterface

interface tsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsr_pkg::PULSE_W-1:0]   tilt_pulse;
    logic [tsr_pkg::PULSE_W-1:0]   pan_pulse;
    logic                          power_on;
    logic                          busy_res;

    modport source (output valid, tilt_pulse, pan_pulse, power_on, busy_res, input ready);
    modport sink   (input valid, tilt_pulse, pan_pulse, power_on, busy_res, output ready);
endinterface

interface tsr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsr_pkg::CFG_IDX_W-1:0]   index;
    logic [tsr_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tsr_cfg.sv
// Configuration register file.
module tsr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [tsr_pkg::CFG_DAT_W-1:0]   i_data,
    output tsr_pkg::t_cfg                   o_cfg
);

    tsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tilt_upper <= tsr_pkg::UPPER_DEFAULT;
            r_cfg.tilt_lower <= tsr_pkg::LOWER_DEFAULT;
            r_cfg.pan_upper  <= tsr_pkg::UPPER_DEFAULT;
            r_cfg.pan_lower  <= tsr_pkg::LOWER_DEFAULT;
            r_cfg.step_scale <= tsr_pkg::SCALE_DEFAULT;
            r_cfg.hold_ticks <= tsr_pkg::HOLD_DEFAULT;
        end else if (i_wr) begin
            case (i_index)
                tsr_pkg::REG_TILT_UPPER: r_cfg.tilt_upper <= i_data;
                tsr_pkg::REG_TILT_LOWER: r_cfg.tilt_lower <= i_data;
                tsr_pkg::REG_PAN_UPPER:  r_cfg.pan_upper  <= i_data;
                tsr_pkg::REG_PAN_LOWER:  r_cfg.pan_lower  <= i_data;
                tsr_pkg::REG_STEP_SCALE: r_cfg.step_scale <= i_data;
                tsr_pkg::REG_HOLD_TICKS: r_cfg.hold_ticks <= i_data;
                // home poses only matter at reset, which always loads the default
                tsr_pkg::REG_TILT_HOME, tsr_pkg::REG_PAN_HOME: ;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/tsr_core.sv
// Move state and per-item next-state logic of both axes.
module tsr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  tsr_pkg::t_cmd   i_cmd,
    input  tsr_pkg::t_cfg   i_cfg,
    output tsr_pkg::t_res   o_res
);

    logic [tsr_pkg::PULSE_W-1:0] r_tilt_now,  n_tilt_now;
    logic [tsr_pkg::PULSE_W-1:0] r_pan_now,   n_pan_now;
    logic [tsr_pkg::PULSE_W-1:0] r_tilt_goal, n_tilt_goal;
    logic [tsr_pkg::PULSE_W-1:0] r_pan_goal,  n_pan_goal;
    logic [tsr_pkg::CNT_W-1:0]   r_interval,  n_interval;
    logic [tsr_pkg::CNT_W-1:0]   r_count,     n_count;
    logic [tsr_pkg::PULSE_W-1:0] r_hold,      n_hold;
    logic [tsr_pkg::PHASE_W-1:0] r_phase,     n_phase;
    logic                        r_power,     n_power;

    logic [tsr_pkg::PULSE_W-1:0] w_goal_tilt;
    logic [tsr_pkg::PULSE_W-1:0] w_goal_pan;
    logic [tsr_pkg::CNT_W-1:0]   w_interval;
    logic [tsr_pkg::CNT_W-1:0]   w_count_inc;
    logic [tsr_pkg::PULSE_W-1:0] w_hold_inc;

    function automatic logic [tsr_pkg::PULSE_W-1:0] clamp_axis(
        input logic [tsr_pkg::PULSE_W-1:0] v,
        input logic [tsr_pkg::PULSE_W-1:0] hi,
        input logic [tsr_pkg::PULSE_W-1:0] lo
    );
        logic [tsr_pkg::PULSE_W-1:0] t;
        t = (v > hi) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

    function automatic logic [tsr_pkg::PULSE_W-1:0] step_toward(
        input logic [tsr_pkg::PULSE_W-1:0] now,
        input logic [tsr_pkg::PULSE_W-1:0] goal
    );
        logic [tsr_pkg::PULSE_W-1:0] r;
        if (now < goal) begin
            r = now + 1'b1;
        end else if (now > goal) begin
            r = now - 1'b1;
        end else begin
            r = now;
        end
        return r;
    endfunction

    // 8x16 product plus one fits in 24 bits
    assign w_goal_tilt = clamp_axis(i_cmd.target_tilt, i_cfg.tilt_upper, i_cfg.tilt_lower);
    assign w_goal_pan  = clamp_axis(i_cmd.target_pan, i_cfg.pan_upper, i_cfg.pan_lower);
    assign w_interval  = tsr_pkg::CNT_W'(i_cmd.speed) * tsr_pkg::CNT_W'(i_cfg.step_scale)
                         + tsr_pkg::CNT_W'(1);
    assign w_count_inc = r_count + tsr_pkg::CNT_W'(1);
    assign w_hold_inc  = (r_hold < tsr_pkg::HOLD_SAT) ? r_hold + 1'b1 : r_hold;

    always_comb begin
        n_tilt_now  = r_tilt_now;
        n_pan_now   = r_pan_now;
        n_tilt_goal = r_tilt_goal;
        n_pan_goal  = r_pan_goal;
        n_interval  = r_interval;
        n_count     = r_count;
        n_hold      = r_hold;
        n_phase     = r_phase;
        n_power     = r_power;
        if (i_cmd.op == tsr_pkg::OP_MOVE) begin
            if (r_phase == tsr_pkg::PH_IDLE) begin
                n_tilt_goal = w_goal_tilt;
                n_pan_goal  = w_goal_pan;
                n_interval  = w_interval;
                n_count     = '0;
                n_hold      = '0;
                if (w_goal_tilt == r_tilt_now && w_goal_pan == r_pan_now) begin
                    n_phase = tsr_pkg::PH_HOLD;
                end else begin
                    n_phase = tsr_pkg::PH_MOVE;
                end
            end
        end else begin
            case (r_phase)
                tsr_pkg::PH_IDLE: ;
                tsr_pkg::PH_MOVE: begin
                    n_count = w_count_inc;
                    if (w_count_inc >= r_interval) begin
                        n_count = '0;
                        n_power = 1'b1;
                        if (r_tilt_now == r_tilt_goal && r_pan_now == r_pan_goal) begin
                            n_hold  = '0;
                            n_phase = tsr_pkg::PH_HOLD;
                        end else begin
                            n_tilt_now = step_toward(r_tilt_now, r_tilt_goal);
                            n_pan_now  = step_toward(r_pan_now, r_pan_goal);
                        end
                    end
                end
                tsr_pkg::PH_HOLD: begin
                    n_hold = w_hold_inc;
                    if (w_hold_inc >= i_cfg.hold_ticks) begin
                        n_hold  = '0;
                        n_power = 1'b0;
                        n_phase = tsr_pkg::PH_IDLE;
                    end
                end
                default: n_phase = tsr_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_now  <= tsr_pkg::HOME_DEFAULT;
            r_pan_now   <= tsr_pkg::HOME_DEFAULT;
            r_tilt_goal <= tsr_pkg::HOME_DEFAULT;
            r_pan_goal  <= tsr_pkg::HOME_DEFAULT;
            r_interval  <= '0;
            r_count     <= '0;
            r_hold      <= '0;
            r_phase     <= tsr_pkg::PH_IDLE;
            r_power     <= 1'b0;
        end else if (i_fire) begin
            r_tilt_now  <= n_tilt_now;
            r_pan_now   <= n_pan_now;
            r_tilt_goal <= n_tilt_goal;
            r_pan_goal  <= n_pan_goal;
            r_interval  <= n_interval;
            r_count     <= n_count;
            r_hold      <= n_hold;
            r_phase     <= n_phase;
            r_power     <= n_power;
        end
    end

    // result shows the state after the item
    assign o_res.tilt_pulse = n_tilt_now;
    assign o_res.pan_pulse  = n_pan_now;
    assign o_res.power_on   = n_power;
    assign o_res.busy_res   = (n_phase != tsr_pkg::PH_IDLE);

`ifndef NO_ASSERTIONS
    a_idle_unpowered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsr_pkg::PH_IDLE) |-> !r_power)
        else $error("power on while idle");

    a_idle_arrived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsr_pkg::PH_IDLE) |-> (r_tilt_now == r_tilt_goal && r_pan_now == r_pan_goal))
        else $error("idle away from goal");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsr_pkg::PH_MOVE) |-> (r_count < r_interval))
        else $error("step counter past interval");

    a_hold_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsr_pkg::PH_HOLD && i_fire) |=> ($stable(r_tilt_now) && $stable(r_pan_now)))
        else $error("axis moved during hold");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsr_pkg::PH_IDLE || r_phase == tsr_pkg::PH_MOVE
         || r_phase == tsr_pkg::PH_HOLD))
        else $error("unused phase code");
`endif

endmodule

>>> rtl/two_axis_servo_slew_ramp.sv
// Top level of the two-axis servo slew ramp: input stage, move core, result stage.
//
//  channel  dir  port   payload                                   transfer when
//  -------  ---  -----  ----------------------------------------  ---------------
//  command  in   i_in   op, target_tilt, target_pan, speed        valid && ready
//  result   out  o_out  tilt_pulse, pan_pulse, power_on, busy_res valid && ready
//  config   in   i_cfg  index (3 bit), data (16 bit)              valid && ready
//
// One item per clock while o_out.ready holds; an item passes the input register, then
// the move core updates its state and the result register in the same edge.
// The state update of the core is the only per-item loop.
// Reset (i_rst_n low, synchronous) loads both axes and goals with the home pose,
// clears the timers and drops power; the register file takes its defaults.
// A stalled result holds the core; the input register then fills and i_in.ready
// falls until the result transfer completes.
// Register writes are always taken; the config port never stalls.
module two_axis_servo_slew_ramp (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsr_in_if.sink     i_in,
    tsr_out_if.source  o_out,
    tsr_cfg_if.sink    i_cfg
);

    logic          r_in_valid;
    tsr_pkg::t_cmd r_in_cmd;
    logic          r_out_valid;
    tsr_pkg::t_res r_out_res;

    logic          w_adv;
    logic          w_in_xfer;
    tsr_pkg::t_cfg w_cfg;
    tsr_pkg::t_res w_res;

    // advance the input item into the core when the result slot is free or draining
    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_xfer = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    tsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    tsr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_cmd   (r_in_cmd),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_cmd.op          <= i_in.op;
            r_in_cmd.target_tilt <= i_in.target_tilt;
            r_in_cmd.target_pan  <= i_in.target_pan;
            r_in_cmd.speed       <= i_in.speed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tilt_pulse = r_out_res.tilt_pulse;
    assign o_out.pan_pulse  = r_out_res.pan_pulse;
    assign o_out.power_on   = r_out_res.power_on;
    assign o_out.busy_res   = r_out_res.busy_res;

endmodule
